### rtl/sbwt_pkg.sv
// Shared types and constants for the subnet burst width tracker.
// No dependencies; used by sbwt_width_calc and the top level.
package sbwt_pkg;

  localparam int PREFIX_SHIFT = 8;
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [10:0] WIDTH_MAX = 11'd1000;

  // floor(x / 1000) = (x * MS_RECIP) >> MS_SHIFT, exact for any 20-bit x
  localparam logic [20:0] MS_RECIP = 21'd1073742;
  localparam int MS_SHIFT = 30;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NEW   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_NONE  = 3'd4;

  // what the second stage does with an item
  localparam logic [2:0] K_HIT  = 3'd0;
  localparam logic [2:0] K_NEW  = 3'd1;
  localparam logic [2:0] K_FULL = 3'd2;
  localparam logic [2:0] K_RPT  = 3'd3;
  localparam logic [2:0] K_NONE = 3'd4;

  typedef struct packed {
    logic [23:0] count;
    logic [31:0] first_sec;
    logic [19:0] first_usec;
    logic [31:0] last_sec;
    logic [19:0] last_usec;
  } group_rec_t;

  typedef struct packed {
    logic       ok;
    logic [9:0] ms;
  } width_t;

endpackage

### rtl/sbwt_group_ram.sv
// Per-group record memory: one write port, one registered read port.
// A read at the address written in the same cycle returns the new record.
module sbwt_group_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

endmodule

### rtl/sbwt_width_calc.sv
// Burst width in ms from a group's first and latest timestamps.
// Uses sbwt_pkg for constants and the width_t result type.
module sbwt_width_calc (
  input  logic [31:0]      first_sec,
  input  logic [19:0]      first_usec,
  input  logic [31:0]      last_sec,
  input  logic [19:0]      last_usec,
  output sbwt_pkg::width_t res
);

  logic [31:0] ds;
  logic [20:0] du;
  logic        neg;
  logic [19:0] mag;
  logic [40:0] prod;
  logic [10:0] q;

  always_comb begin
    ds   = last_sec - first_sec;
    du   = {1'b0, last_usec} - {1'b0, first_usec};
    neg  = du[20];
    mag  = neg ? 20'(-du) : du[19:0];
    prod = 41'(mag) * 41'(sbwt_pkg::MS_RECIP);
    q    = prod[sbwt_pkg::MS_SHIFT +: 11];
    res  = '0;
    if (ds == 32'd0 && !neg) begin
      res.ok = (q <= sbwt_pkg::WIDTH_MAX);
      res.ms = res.ok ? q[9:0] : 10'd0;
    end else if (ds == 32'd1 && (neg || mag == 20'd0)) begin
      res.ok = (q <= sbwt_pkg::WIDTH_MAX);
      res.ms = res.ok ? 10'(sbwt_pkg::WIDTH_MAX - q) : 10'd0;
    end
  end

endmodule

### rtl/subnet_burst_width_tracker_top.sv
// Top level of the subnet burst width tracker.
// Depends on sbwt_pkg, sbwt_group_ram and sbwt_width_calc.
//
// Usage: the slave channel takes one item per handshake. s_tuser = 1 asks
// for a report on group group_sel; s_tuser = 0 is a packet arrival whose
// source /24 prefix is matched against the groups in use, joining a group,
// opening a new one, or being dropped when all GROUP_SLOTS slots are taken.
// Every item gives exactly one result item on the master channel, in order.
//
// Timing: an item passes an input register, a stage that reads the group
// record memory (one registered read port) and an output register, in that
// order, before m_tvalid rises. One item is accepted every cycle while the
// receiver takes results; back-to-back packets of the same group are served
// by a write-first bypass on the memory.
//
// Reset clears the group count and all valid flags; the record memory is
// not cleared since only records of groups already opened are ever used. When the
// receiver stalls, the pipeline holds and s_tready drops once all three
// stages are full.
module subnet_burst_width_tracker_top #(
  parameter int GROUP_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // fields from bit 0: ip_src[32], ts_sec[32], ts_usec[20], group_sel[4]
  input  logic [87:0] s_tdata,
  // fields from bit 0: command[1]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // fields from bit 0: group[4], net_prefix[24], pkt_count[24], width_ms[10], zero pad[2]
  output logic [63:0] m_tdata,
  // fields from bit 0: status[3]
  output logic [2:0]  m_tuser
);

  localparam int IDXW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int CNTW = $clog2(GROUP_SLOTS + 1);
  localparam int RECW = $bits(sbwt_pkg::group_rec_t);

  // flow control
  logic v1, v2, vo;
  logic adv1, adv2;

  assign adv2     = !vo || m_tready;
  assign adv1     = !v2 || adv2;
  assign s_tready = !v1 || adv1;

  // input register
  logic        cmd1;
  logic [23:0] pfx1;
  logic [31:0] sec1;
  logic [19:0] usec1;
  logic [3:0]  sel1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd1  <= s_tuser;
      pfx1  <= s_tdata[31:sbwt_pkg::PREFIX_SHIFT];
      sec1  <= s_tdata[63:32];
      usec1 <= s_tdata[83:64];
      sel1  <= s_tdata[87:84];
    end
  end

  // group table: prefixes in flops for the parallel match
  logic [23:0]       prefix_tab [GROUP_SLOTS];
  logic [CNTW-1:0]   used;
  logic [GROUP_SLOTS-1:0] hit_vec;
  logic              hit;
  logic [IDXW-1:0]   hit_idx;
  logic              full;
  logic              sel_none;
  logic [IDXW-1:0]   sel_idx;
  logic [2:0]        kind1;
  logic [IDXW-1:0]   idx1;
  logic [IDXW+3:0]   idx_ext;
  logic [3:0]        grp1;
  logic [23:0]       pfx_out1;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < GROUP_SLOTS; i++) begin
      hit_vec[i] = (CNTW'(i) < used) && (prefix_tab[i] == pfx1);
    end
    for (int i = GROUP_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDXW'(i);
      end
    end
    hit      = |hit_vec;
    full     = (used == CNTW'(GROUP_SLOTS));
    sel_idx  = IDXW'(sel1);
    sel_none = (32'(sel1) >= 32'(used));

    if (cmd1) begin
      kind1 = sel_none ? sbwt_pkg::K_NONE : sbwt_pkg::K_RPT;
      idx1  = sel_idx;
    end else if (hit) begin
      kind1 = sbwt_pkg::K_HIT;
      idx1  = hit_idx;
    end else if (full) begin
      kind1 = sbwt_pkg::K_FULL;
      idx1  = '0;
    end else begin
      kind1 = sbwt_pkg::K_NEW;
      idx1  = IDXW'(used);
    end

    idx_ext  = (IDXW + 4)'(idx1);
    grp1     = cmd1 ? sel1 : idx_ext[3:0];
    pfx_out1 = pfx1;
    if (cmd1) begin
      pfx_out1 = sel_none ? 24'd0 : prefix_tab[sel_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (v1 && adv1 && kind1 == sbwt_pkg::K_NEW) begin
      used <= used + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && adv1 && kind1 == sbwt_pkg::K_NEW) begin
      prefix_tab[idx1] <= pfx1;
    end
  end

  // second stage: record read done, update and result build
  logic [2:0]      kind2;
  logic [IDXW-1:0] idx2;
  logic [3:0]      grp2;
  logic [23:0]     pfx2;
  logic [31:0]     sec2;
  logic [19:0]     usec2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv1) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && adv1) begin
      kind2 <= kind1;
      idx2  <= idx1;
      grp2  <= grp1;
      pfx2  <= pfx_out1;
      sec2  <= sec1;
      usec2 <= usec1;
    end
  end

  sbwt_pkg::group_rec_t rec, wrec;
  logic [RECW-1:0] rdata;
  logic            we;
  logic [23:0]     cnt_inc;
  sbwt_pkg::width_t wres;

  assign rec = sbwt_pkg::group_rec_t'(rdata);
  assign we  = v2 && adv2 && (kind2 == sbwt_pkg::K_HIT || kind2 == sbwt_pkg::K_NEW);

  sbwt_group_ram #(
    .DEPTH (GROUP_SLOTS),
    .AW    (IDXW),
    .DW    (RECW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx2),
    .wdata (RECW'(wrec)),
    .re    (v1 && adv1),
    .raddr (idx1),
    .rdata (rdata)
  );

  sbwt_width_calc u_width (
    .first_sec  (rec.first_sec),
    .first_usec (rec.first_usec),
    .last_sec   (rec.last_sec),
    .last_usec  (rec.last_usec),
    .res        (wres)
  );

  logic [2:0]  st_next;
  logic [23:0] cnt_next;
  logic [9:0]  w_next;

  always_comb begin
    cnt_inc = (rec.count == sbwt_pkg::COUNT_MAX) ? sbwt_pkg::COUNT_MAX : rec.count + 24'd1;
    wrec = rec;
    wrec.last_sec  = sec2;
    wrec.last_usec = usec2;
    st_next  = sbwt_pkg::ST_OK;
    cnt_next = 24'd0;
    w_next   = 10'd0;
    unique case (kind2)
      sbwt_pkg::K_HIT: begin
        wrec.count = cnt_inc;
        cnt_next   = cnt_inc;
      end
      sbwt_pkg::K_NEW: begin
        wrec.count      = 24'd1;
        wrec.first_sec  = sec2;
        wrec.first_usec = usec2;
        st_next  = sbwt_pkg::ST_NEW;
        cnt_next = 24'd1;
      end
      sbwt_pkg::K_FULL: begin
        st_next = sbwt_pkg::ST_FULL;
      end
      sbwt_pkg::K_RPT: begin
        st_next  = wres.ok ? sbwt_pkg::ST_OK : sbwt_pkg::ST_RANGE;
        cnt_next = rec.count;
        w_next   = wres.ms;
      end
      default: begin
        st_next = sbwt_pkg::ST_NONE;
      end
    endcase
  end

  // output register
  logic [3:0]  o_group;
  logic [2:0]  o_status;
  logic [23:0] o_pfx;
  logic [23:0] o_cnt;
  logic [9:0]  o_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (adv2) begin
      vo <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && adv2) begin
      o_group  <= grp2;
      o_status <= st_next;
      o_pfx    <= pfx2;
      o_cnt    <= cnt_next;
      o_w      <= w_next;
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = {2'b00, o_w, o_cnt, o_pfx, o_group};
  assign m_tuser  = o_status;

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNTW'(GROUP_SLOTS))
    else $error("group count above slot count");

  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    (v1 && adv1 && kind1 == sbwt_pkg::K_NEW) |=> (used == $past(used) + CNTW'(1)))
    else $error("new group did not bump group count");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (v1 && kind1 == sbwt_pkg::K_FULL) |-> full)
    else $error("packet dropped while a slot is free");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && vo && !m_tready) |-> !s_tready)
    else $error("input taken while pipeline full and stalled");

endmodule
